@@ rtl/dnsq_pkg.sv @@
// Shared types, constants and helpers of the DNS question encoder.
package dnsq_pkg;

   localparam int LABEL_MAX_DEF = 32;

   localparam logic [7:0]  DOT_CHAR       = 8'h2e;
   localparam logic [7:0]  UPPER_FIRST    = 8'h41;
   localparam logic [7:0]  UPPER_LAST     = 8'h5a;
   localparam logic [7:0]  CASE_OFFSET    = 8'h20;
   localparam logic [7:0]  ROOT_BYTE      = 8'h00;
   localparam logic [7:0]  CLASS_IN_HI    = 8'h00;
   localparam logic [7:0]  CLASS_IN_LO    = 8'h01;
   localparam logic [15:0] QUERY_TYPE_RST = 16'h0001;

   localparam int CSR_ADDR_W = 3;

   typedef enum logic [0:0] {
      CSR_QUERY_TYPE = 1'b0
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_LEN,
      ST_CHR,
      ST_TRL_ZERO,
      ST_TRL_QT_HI,
      ST_TRL_QT_LO,
      ST_TRL_CLS_HI,
      ST_TRL_CLS_LO
   } state_type;

   typedef enum logic [2:0] {
      OUT_NONE,
      OUT_LEN,
      OUT_CHR,
      OUT_ZERO,
      OUT_QT_HI,
      OUT_QT_LO,
      OUT_CLASS_HI,
      OUT_CLASS_LO
   } out_sel_type;

   typedef struct packed {
      out_sel_type out_sel;
      logic        take_item;
      logic        clear_label;
      logic        clear_name;
   } cmd_type;

   typedef struct packed {
      logic count_zero;
      logic chr_last;
      logic out_free;
      logic in_dot;
   } status_type;

   function automatic logic [7:0] fold_char(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c >= UPPER_FIRST && c <= UPPER_LAST) begin
         r = c + CASE_OFFSET;
      end
      return r;
   endfunction

endpackage

@@ rtl/dnsq_if.sv @@
// Word channel interfaces for the character input and the byte output.
interface dnsq_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;
   logic       name_end;

   modport source (output valid, output ch, output name_end, input ready);
   modport sink   (input valid, input ch, input name_end, output ready);
endinterface

interface dnsq_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       end_of_question;
   logic       label_overflow;

   modport source (output valid, output out_byte, output end_of_question,
                   output label_overflow, input ready);
   modport sink   (input valid, input out_byte, input end_of_question,
                   input label_overflow, output ready);
endinterface

@@ rtl/dnsq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module dnsq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/dnsq_ctrl.sv @@
// Controller state machine that sequences label flushes and the trailer.
module dnsq_ctrl
   import dnsq_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_name_end,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      last_ff, last_in;
   logic      accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         last_ff  <= last_in;
      end
   end

   always_comb begin
      last_in = last_ff;
      if (accept) begin
         last_in = req_name_end;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (status.in_dot || req_name_end)) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (!status.count_zero) begin
               state_in = ST_LEN;
            end else if (last_ff) begin
               state_in = ST_TRL_ZERO;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_LEN: begin
            if (status.out_free) begin
               state_in = ST_CHR;
            end
         end
         ST_CHR: begin
            if (status.out_free && status.chr_last) begin
               state_in = last_ff ? ST_TRL_ZERO : ST_IDLE;
            end
         end
         ST_TRL_ZERO: begin
            if (status.out_free) begin
               state_in = ST_TRL_QT_HI;
            end
         end
         ST_TRL_QT_HI: begin
            if (status.out_free) begin
               state_in = ST_TRL_QT_LO;
            end
         end
         ST_TRL_QT_LO: begin
            if (status.out_free) begin
               state_in = ST_TRL_CLS_HI;
            end
         end
         ST_TRL_CLS_HI: begin
            if (status.out_free) begin
               state_in = ST_TRL_CLS_LO;
            end
         end
         ST_TRL_CLS_LO: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Commands to the datapath.
   always_comb begin
      cmd.out_sel     = OUT_NONE;
      cmd.take_item   = accept;
      cmd.clear_label = 1'b0;
      cmd.clear_name  = 1'b0;
      case (state_ff)
         ST_LEN: begin
            if (status.out_free) begin
               cmd.out_sel = OUT_LEN;
            end
         end
         ST_CHR: begin
            if (status.out_free) begin
               cmd.out_sel     = OUT_CHR;
               cmd.clear_label = status.chr_last;
            end
         end
         ST_TRL_ZERO: begin
            if (status.out_free) begin
               cmd.out_sel = OUT_ZERO;
            end
         end
         ST_TRL_QT_HI: begin
            if (status.out_free) begin
               cmd.out_sel = OUT_QT_HI;
            end
         end
         ST_TRL_QT_LO: begin
            if (status.out_free) begin
               cmd.out_sel = OUT_QT_LO;
            end
         end
         ST_TRL_CLS_HI: begin
            if (status.out_free) begin
               cmd.out_sel = OUT_CLASS_HI;
            end
         end
         ST_TRL_CLS_LO: begin
            if (status.out_free) begin
               cmd.out_sel    = OUT_CLASS_LO;
               cmd.clear_name = 1'b1;
            end
         end
         default: begin
            cmd.out_sel = OUT_NONE;
         end
      endcase
   end

endmodule

@@ rtl/dnsq_datapath.sv @@
// Datapath: label buffer, label count, overflow flag and output register.
module dnsq_datapath
   import dnsq_pkg::*;
#(
   parameter int LABEL_MAX = LABEL_MAX_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [7:0]  req_ch,
   input  logic [15:0] query_type,
   input  cmd_type     cmd,
   output status_type  status,
   input  logic        rsp_ready,
   output logic        rsp_valid,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_end_of_question,
   output logic        rsp_label_overflow
);

   localparam int CNT_W = $clog2(LABEL_MAX + 1);
   localparam int IDX_W = (LABEL_MAX > 1) ? $clog2(LABEL_MAX) : 1;

   logic [CNT_W-1:0] count_ff, count_in;
   logic             overflow_ff, overflow_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       byte_ff, byte_in;
   logic             end_ff, end_in;
   logic             ovf_out_ff, ovf_out_in;

   logic             is_dot;
   logic             has_room;
   logic             wr_en;
   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   logic [7:0]       rd_data;
   logic [CNT_W-1:0] idx_next;
   logic             load;

   assign is_dot   = (req_ch == DOT_CHAR);
   assign has_room = (count_ff < CNT_W'(LABEL_MAX));
   assign wr_en    = cmd.take_item && !is_dot && has_room;
   assign idx_next = CNT_W'(idx_ff) + CNT_W'(1);
   assign load     = (cmd.out_sel != OUT_NONE);

   assign status.count_zero = (count_ff == '0);
   assign status.chr_last   = (idx_next == count_ff);
   assign status.out_free   = !rsp_valid_ff || rsp_ready;
   assign status.in_dot     = is_dot;

   // The read for the first character goes out with the length byte, and
   // each later read goes out as the previous character is loaded.
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = '0;
      idx_in  = idx_ff;
      if (cmd.out_sel == OUT_LEN) begin
         rd_en  = 1'b1;
         idx_in = '0;
      end else if (cmd.out_sel == OUT_CHR && !status.chr_last) begin
         rd_en   = 1'b1;
         rd_addr = idx_next[IDX_W-1:0];
         idx_in  = idx_next[IDX_W-1:0];
      end
   end

   dnsq_ram #(
      .WIDTH (8),
      .DEPTH (LABEL_MAX)
   ) u_label_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (fold_char(req_ch)),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      count_in    = count_ff;
      overflow_in = overflow_ff;
      if (cmd.clear_name || cmd.clear_label) begin
         count_in = '0;
      end else if (wr_en) begin
         count_in = count_ff + CNT_W'(1);
      end
      if (cmd.clear_name) begin
         overflow_in = 1'b0;
      end else if (cmd.take_item && !is_dot && !has_room) begin
         overflow_in = 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      byte_in      = byte_ff;
      end_in       = end_ff;
      ovf_out_in   = ovf_out_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         ovf_out_in   = overflow_ff;
         end_in       = 1'b0;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (cmd.out_sel)
         OUT_LEN:      byte_in = 8'(count_ff);
         OUT_CHR:      byte_in = rd_data;
         OUT_ZERO:     byte_in = ROOT_BYTE;
         OUT_QT_HI:    byte_in = query_type[15:8];
         OUT_QT_LO:    byte_in = query_type[7:0];
         OUT_CLASS_HI: byte_in = CLASS_IN_HI;
         OUT_CLASS_LO: begin
            byte_in = CLASS_IN_LO;
            end_in  = 1'b1;
         end
         default: begin
            byte_in = byte_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         overflow_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         overflow_ff  <= overflow_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff     <= idx_in;
      byte_ff    <= byte_in;
      end_ff     <= end_in;
      ovf_out_ff <= ovf_out_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_out_byte        = byte_ff;
   assign rsp_end_of_question = end_ff;
   assign rsp_label_overflow  = ovf_out_ff;

endmodule

@@ rtl/dns_question_encoder.sv @@
// Top level of the DNS question encoder: channels, register port and wiring.
//
// The block takes a dotted domain name one character word at a time on the
// req channel (ch, name_end) and gives the wire-format question section one
// byte word at a time on the rsp channel. Letters A to Z are folded to lower
// case. Each label is buffered in a small RAM and emitted as a length byte
// followed by its characters when a dot or the last character closes it;
// empty labels give nothing. After the last character come a zero byte, the
// two query_type bytes (high first) and the class bytes 00 01, the final one
// marked by end_of_question. Characters beyond LABEL_MAX in one label are
// dropped and label_overflow is raised on the bytes that follow, until the
// end of that name.
// An ordinary character is taken and the block stays ready for more. A dot
// or a last character first goes through the count check, then the bytes
// go out: the label length plus one, and five more after the last
// character. The output register and the serial read of the label RAM give
// one byte a cycle while the rsp receiver is ready.
// The req channel is only ready while the controller is idle. When the rsp
// receiver stalls, the output register holds its word and the sequence
// waits. query_type is written through the APB port at byte address 0.
// Reset is synchronous: it empties the label, clears the overflow flag, sets
// query_type to 1 and drops rsp valid.
module dns_question_encoder
   import dnsq_pkg::*;
#(
   parameter int LABEL_MAX = LABEL_MAX_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   dnsq_req_if.sink              req,
   dnsq_rsp_if.source            rsp,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   cmd_type     cmd;
   status_type  status;
   logic [15:0] query_type_ff, query_type_in;
   logic        csr_write;
   logic        csr_hit;

   // Register index sits in the word address bit; byte lanes are ignored.
   assign csr_hit   = (csr_index_type'(paddr[2]) == CSR_QUERY_TYPE);
   assign csr_write = psel && penable && pwrite;
   assign pready    = 1'b1;

   always_comb begin
      query_type_in = query_type_ff;
      if (csr_write && csr_hit) begin
         query_type_in = pwdata[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         query_type_ff <= QUERY_TYPE_RST;
      end else begin
         query_type_ff <= query_type_in;
      end
   end

   assign prdata = csr_hit ? {16'h0000, query_type_ff} : 32'h0000_0000;

   dnsq_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req.valid),
      .req_name_end (req.name_end),
      .req_ready    (req.ready),
      .status       (status),
      .cmd          (cmd)
   );

   dnsq_datapath #(
      .LABEL_MAX (LABEL_MAX)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .req_ch              (req.ch),
      .query_type          (query_type_ff),
      .cmd                 (cmd),
      .status              (status),
      .rsp_ready           (rsp.ready),
      .rsp_valid           (rsp.valid),
      .rsp_out_byte        (rsp.out_byte),
      .rsp_end_of_question (rsp.end_of_question),
      .rsp_label_overflow  (rsp.label_overflow)
   );

endmodule

@@ tb/dns_question_encoder_test.sv @@
// Self-checking testbench of the DNS question encoder, with its own byte-level predictor.
module dns_question_encoder_test
   import dnsq_pkg::*;
();

   // Timing of the run. The timeout is far beyond the slowest legal run,
   // which is every name stalled by the receiver on every byte word.
   localparam int CLOCK_PERIOD  = 12;
   localparam int RESET_CYCLES  = 7;
   localparam int TIMEOUT_TICKS = CLOCK_PERIOD * 1_000_000;
   localparam int DRAIN_LIMIT   = 50_000;
   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_CYCLES   = 400;

   // The encoder's label buffer depth and the fixed bytes of the question.
   localparam int          NAME_LABEL_MAX = LABEL_MAX_DEF;
   localparam logic [7:0]  DOT            = 8'h2e;
   localparam logic [7:0]  ROOT_LABEL     = 8'h00;
   localparam logic [15:0] CLASS_IN       = 16'h0001;

   // The random part is split into phases, each with its own query type.
   localparam int PHASES          = 5;
   localparam int WORDS_PER_PHASE = 56;
   localparam logic [15:0] PHASE_TYPES [PHASES] = '{
      16'h0000, 16'hffff, 16'h001c, 16'h0000, 16'h0001
   };
   localparam int RANDOM_TYPE_PHASE = 3;
   localparam int HOLD_PHASE        = 1;

   // One byte word of the question section, as it appears on the rsp channel.
   typedef struct packed {
      logic [7:0] out_byte;
      logic       end_of_question;
      logic       label_overflow;
   } question_byte_type;

   // A row of the directed table: a character sent `repeats` times, with
   // name_end on the last copy only. Where fixed_n is non-zero the result of
   // the row is typed in by hand (first byte in the top bits, overflow clear,
   // end of question on the last byte) instead of being taken from the
   // predictor.
   typedef struct packed {
      logic [7:0]  ch;
      logic        name_end;
      logic [7:0]  repeats;
      logic [2:0]  fixed_n;
      logic [55:0] fixed_bytes;
   } directed_row_type;

   localparam int DIRECTED_ROWS = 25;
   localparam directed_row_type DIRECTED_TABLE [DIRECTED_ROWS] = '{
      // The root name straight after reset: zero label, type 1, class IN.
      '{8'h2e, 1'b1, 8'd1, 3'd5, {40'h00_0001_0001, 16'h0000}},
      // A single upper-case letter as a whole name, folded to lower case.
      '{8'h41, 1'b1, 8'd1, 3'd7, 56'h01_61_00_0001_0001},
      // Either side of the letter range, its upper end, a and z, and odd bytes.
      '{8'h40, 1'b0, 8'd1, 3'd0, 56'h0},
      '{8'h5b, 1'b0, 8'd1, 3'd0, 56'h0},
      '{8'h5a, 1'b0, 8'd1, 3'd0, 56'h0},
      '{8'h61, 1'b0, 8'd1, 3'd0, 56'h0},
      '{8'h7a, 1'b0, 8'd1, 3'd0, 56'h0},
      '{8'h00, 1'b0, 8'd1, 3'd0, 56'h0},
      '{8'hff, 1'b0, 8'd1, 3'd0, 56'h0},
      // A dot closes the label, and a doubled dot gives nothing.
      '{8'h2e, 1'b0, 8'd1, 3'd0, 56'h0},
      '{8'h2e, 1'b0, 8'd1, 3'd0, 56'h0},
      '{8'h39, 1'b1, 8'd1, 3'd0, 56'h0},
      // Leading dots are skipped.
      '{8'h2e, 1'b0, 8'd1, 3'd0, 56'h0},
      '{8'h2e, 1'b0, 8'd1, 3'd0, 56'h0},
      '{8'h51, 1'b1, 8'd1, 3'd7, 56'h01_71_00_0001_0001},
      // A label of exactly the buffer depth, then one that overflows and
      // is closed by a dot, so the flag shows on the rest of the name.
      '{8'h62, 1'b0, 8'd32, 3'd0, 56'h0},
      '{8'h2e, 1'b0, 8'd1, 3'd0, 56'h0},
      '{8'h43, 1'b0, 8'd40, 3'd0, 56'h0},
      '{8'h2e, 1'b0, 8'd1, 3'd0, 56'h0},
      '{8'h64, 1'b1, 8'd1, 3'd0, 56'h0},
      // A clean label first, then an overflow on the final label.
      '{8'h65, 1'b0, 8'd2, 3'd0, 56'h0},
      '{8'h2e, 1'b0, 8'd1, 3'd0, 56'h0},
      '{8'h4d, 1'b1, 8'd35, 3'd0, 56'h0},
      // A trailing dot that carries the end of the name.
      '{8'h78, 1'b0, 8'd1, 3'd0, 56'h0},
      '{8'h2e, 1'b1, 8'd1, 3'd0, 56'h0}
   };

   logic                  clock;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [31:0]           pwdata;
   logic [31:0]           prdata;
   logic                  pready;

   dnsq_req_if req_chan ();
   dnsq_rsp_if rsp_chan ();

   dns_question_encoder #(
      .LABEL_MAX (NAME_LABEL_MAX)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req     (req_chan),
      .rsp     (rsp_chan),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // Predictor state: the open label, the sticky overflow flag of the name
   // and our own copy of the query_type register.
   logic [7:0]  label_chars [NAME_LABEL_MAX];
   int          label_len       = 0;
   logic        name_overflow   = 1'b0;
   logic [15:0] query_type_copy = QUERY_TYPE_RST;

   // Bytes predicted for the word just taken, and the bytes still owed by
   // the encoder, oldest first.
   question_byte_type step_bytes [$];
   question_byte_type pending_bytes [$];

   int mismatches     = 0;
   int words_accepted = 0;

   // Shared between the stimulus and the receiver: whether random idling is
   // on, and a one-off request for a long receiver stall.
   bit idle_on        = 1'b1;
   bit hold_requested = 1'b0;

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // Safety net: a run that hangs is a failed run.
   initial begin
      #(TIMEOUT_TICKS);
      $display("end of test: mismatches");
      $finish;
   end

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------

   // Every byte carries the overflow flag as it stands after the current
   // character has been taken in.
   function automatic void emit_byte(input logic [7:0] value, input logic final_byte);
      step_bytes.push_back('{value, final_byte, name_overflow});
   endfunction

   // A non-empty label goes out as its length followed by its characters;
   // an empty one gives nothing at all.
   function automatic void flush_label();
      if (label_len != 0) begin
         emit_byte(8'(label_len), 1'b0);
         for (int i = 0; i < label_len; i++) begin
            emit_byte(label_chars[i], 1'b0);
         end
         label_len = 0;
      end
   endfunction

   // Works out the bytes that one character word causes. A dot only closes
   // the label; any other byte, zero included, is a label character, and
   // only A to Z are folded. Characters beyond the buffer depth are dropped.
   function automatic void encode_word(input logic [7:0] c, input logic last);
      logic [7:0] folded;
      step_bytes.delete();
      if (c == DOT) begin
         flush_label();
      end else begin
         folded = (c >= 8'h41 && c <= 8'h5a) ? c + 8'h20 : c;
         if (label_len < NAME_LABEL_MAX) begin
            label_chars[label_len] = folded;
            label_len++;
         end else begin
            name_overflow = 1'b1;
         end
      end
      // On the last character the open label is flushed, then the root
      // label, the query type high byte first and the class follow. The
      // next word starts a fresh name.
      if (last) begin
         flush_label();
         emit_byte(ROOT_LABEL, 1'b0);
         emit_byte(query_type_copy[15:8], 1'b0);
         emit_byte(query_type_copy[7:0], 1'b0);
         emit_byte(CLASS_IN[15:8], 1'b0);
         emit_byte(CLASS_IN[7:0], 1'b1);
         label_len     = 0;
         name_overflow = 1'b0;
      end
   endfunction

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------

   // Offers one character word, with a random gap in front of it while
   // idling is on, and waits for the handshake. Once the word is taken the
   // predictor advances; a hand-typed result, where given, replaces the
   // predicted bytes in the store of owed bytes.
   task automatic send_word(input logic [7:0] c, input logic last,
                            input int fixed_n, input logic [55:0] fixed_bytes);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_chan.valid    <= 1'b1;
      req_chan.ch       <= c;
      req_chan.name_end <= last;
      do @(posedge clock); while (!req_chan.ready);
      words_accepted++;
      encode_word(c, last);
      if (fixed_n != 0) begin
         for (int k = 0; k < fixed_n; k++) begin
            pending_bytes.push_back('{fixed_bytes[55 - 8 * k -: 8], k == fixed_n - 1, 1'b0});
         end
      end else begin
         foreach (step_bytes[i]) pending_bytes.push_back(step_bytes[i]);
      end
   endtask

   // Any byte but a dot, weighted towards the characters of real names.
   function automatic logic [7:0] pick_char();
      logic [7:0] c;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: c = 8'($urandom_range(8'h61, 8'h7a));
         4, 5, 6:    c = 8'($urandom_range(8'h41, 8'h5a));
         7:          c = 8'($urandom_range(8'h2d, 8'h39));
         default:    c = 8'($urandom);
      endcase
      while (c == DOT) c = 8'($urandom);
      return c;
   endfunction

   // A well-formed name with random content: mostly short labels, now and
   // then one around the buffer depth, with the odd leading, doubled or
   // trailing dot, and sometimes just the root name.
   task automatic send_name();
      logic [8:0] words [$];
      int         labels;
      int         len;
      labels = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 4);
      if (labels == 0 || $urandom_range(0, 7) == 0) begin
         words.push_back({1'b0, DOT});
      end
      for (int l = 0; l < labels; l++) begin
         len = ($urandom_range(0, 11) == 0) ?
               $urandom_range(NAME_LABEL_MAX - 2, NAME_LABEL_MAX + 4) :
               $urandom_range(1, 10);
         for (int k = 0; k < len; k++) words.push_back({1'b0, pick_char()});
         if (l < labels - 1) begin
            words.push_back({1'b0, DOT});
            if ($urandom_range(0, 9) == 0) words.push_back({1'b0, DOT});
         end
      end
      if (labels != 0 && $urandom_range(0, 5) == 0) words.push_back({1'b0, DOT});
      words[words.size() - 1][8] = 1'b1;
      foreach (words[i]) send_word(words[i][7:0], words[i][8], 0, '0);
   endtask

   // Noise: raw bytes, dots among them, with name_end dropped in at random.
   task automatic send_noise();
      repeat ($urandom_range(1, 6)) begin
         send_word(8'($urandom), $urandom_range(0, 4) == 0, 0, '0);
      end
   endtask

   // Stops offering words and waits until every owed byte has come. A dot on
   // an empty label gives no byte but keeps the encoder busy with its count
   // check, hence the settling time after.
   task automatic drain_and_settle();
      int waited;
      waited = 0;
      req_chan.valid <= 1'b0;
      while (pending_bytes.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (pending_bytes.size() != 0) begin
         $display("%0t: expected %0d more byte words, first %02h, actual none", $time,
                  pending_bytes.size(), pending_bytes[0].out_byte);
         mismatches += pending_bytes.size();
         pending_bytes.delete();
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One APB transfer to query_type: the setup phase, then the access phase
   // that completes on pready. A read is compared with our copy of the
   // register. Dropping psel at the end keeps back-to-back transfers apart.
   task automatic csr_access(input logic write_en, input logic [15:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= write_en;
      paddr   <= CSR_ADDR_W'(4 * int'(CSR_QUERY_TYPE));
      pwdata  <= {16'h0000, value};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (write_en) begin
         query_type_copy = value;
      end else if (prdata[15:0] !== query_type_copy) begin
         $display("%0t: query_type read back expected %04h, actual %04h", $time,
                  query_type_copy, prdata[15:0]);
         mismatches++;
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // Main sequence: reset, the directed table, then random phases with a
   // fresh query type each. The last phase runs without idling.
   initial begin
      logic [15:0] phase_type;
      int          random_base;
      reset             <= 1'b1;
      psel              <= 1'b0;
      penable           <= 1'b0;
      pwrite            <= 1'b0;
      paddr             <= '0;
      pwdata            <= '0;
      req_chan.valid    <= 1'b0;
      req_chan.ch       <= '0;
      req_chan.name_end <= 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // The register must read back its reset value before any write.
      csr_access(1'b0, '0);

      foreach (DIRECTED_TABLE[r]) begin
         for (int k = 0; k < int'(DIRECTED_TABLE[r].repeats); k++) begin
            send_word(DIRECTED_TABLE[r].ch,
                      DIRECTED_TABLE[r].name_end && (k == DIRECTED_TABLE[r].repeats - 1),
                      DIRECTED_TABLE[r].fixed_n, DIRECTED_TABLE[r].fixed_bytes);
         end
      end
      drain_and_settle();

      random_base = words_accepted;
      for (int p = 0; p < PHASES; p++) begin
         phase_type = (p == RANDOM_TYPE_PHASE) ? 16'($urandom) : PHASE_TYPES[p];
         csr_access(1'b1, phase_type);
         csr_access(1'b0, '0);
         idle_on = (p != PHASES - 1);
         // In one phase the receiver holds off for a long stretch while we
         // keep offering words, so the encoder fills up and stalls req.
         if (p == HOLD_PHASE) hold_requested = 1'b1;
         while (words_accepted - random_base < (p + 1) * WORDS_PER_PHASE) begin
            if ($urandom_range(0, 6) == 0) begin
               send_noise();
            end else begin
               send_name();
            end
         end
         drain_and_settle();
      end

      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // ------------------------------------------------------------------
   // Receiver and checking
   // ------------------------------------------------------------------

   // Receiver: random stalls while idling is on, runs of steady readiness
   // between them, and the one long hold-off on request.
   initial begin
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_requested) begin
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_requested = 1'b0;
         end else if (idle_on && $urandom_range(0, 3) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
         end else begin
            rsp_chan.ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge clock);
         end
      end
   end

   function automatic void check_field(input string what, input logic [7:0] want,
                                       input logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %02h, actual %02h", $time, what, want, got);
         mismatches++;
      end
   endfunction

   // Every byte word taken from the encoder is held against the oldest one
   // still owed, field by field.
   always @(posedge clock) begin
      question_byte_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_bytes.size() == 0) begin
            $display("%0t: no byte word expected, actual %02h eoq %b ovf %b", $time,
                     rsp_chan.out_byte, rsp_chan.end_of_question,
                     rsp_chan.label_overflow);
            mismatches++;
         end else begin
            want = pending_bytes.pop_front();
            check_field("out_byte", want.out_byte, rsp_chan.out_byte);
            check_field("end_of_question", 8'(want.end_of_question),
                        8'(rsp_chan.end_of_question));
            check_field("label_overflow", 8'(want.label_overflow),
                        8'(rsp_chan.label_overflow));
         end
      end
   end

endmodule
